### rtl/core/tea_block_encrypt_defines.svh
// ----------------------------------------------------------------------------
// TEA block encrypt assertion macros
// Shared concurrent assertion forms used by the encryption core.
// ----------------------------------------------------------------------------
`ifndef TEA_BLOCK_ENCRYPT_DEFINES_SVH
`define TEA_BLOCK_ENCRYPT_DEFINES_SVH

// Same-cycle implication, disabled while the reset input is high.
`define TEA_ASSERT_IMP(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("tea core check failed");

// Next-cycle implication, disabled while the reset input is high.
`define TEA_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("tea core check failed");

`endif

### rtl/core/tea_pkg.sv
// ----------------------------------------------------------------------------
// TEA package
// Types, constants and the per-round sum function of the TEA core.
// ----------------------------------------------------------------------------
package tea_pkg;

   localparam int WordWidth       = 32;
   localparam int DefRoundCount   = 32;
   localparam int CsrIndexWidth   = 8;
   localparam logic [WordWidth-1:0] TeaDelta = 32'h9e3779b9;

   // Register indexes of the configuration port.
   localparam logic [CsrIndexWidth-1:0] KEY_WORD0_IDX = 8'd0;
   localparam logic [CsrIndexWidth-1:0] KEY_WORD1_IDX = 8'd1;
   localparam logic [CsrIndexWidth-1:0] KEY_WORD2_IDX = 8'd2;
   localparam logic [CsrIndexWidth-1:0] KEY_WORD3_IDX = 8'd3;

   typedef logic [WordWidth-1:0] word_type;

   typedef struct packed {
      word_type right;
      word_type left;
   } block_type;

   // Running sum after round r (counted from zero), modulo 2^32.
   function automatic word_type round_sum(input int r);
      word_type count;
      count = WordWidth'(r + 1);
      return WordWidth'(TeaDelta * count);
   endfunction

endpackage

### rtl/core/tea_half_round.sv
// ----------------------------------------------------------------------------
// TEA half round stage
// One registered pipeline stage that updates one half of the block.
// ----------------------------------------------------------------------------
module tea_half_round
   import tea_pkg::*;
#(
   parameter bit       UPDATE_LEFT = 1'b1,
   parameter word_type ROUND_SUM   = TeaDelta
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      stage_en,
   input  logic      in_valid,
   input  block_type in_blk,
   input  word_type  key_a,
   input  word_type  key_b,
   output logic      out_valid,
   output block_type out_blk
);

   logic      valid_ff;
   block_type blk_ff;
   block_type blk_in;
   word_type  src;
   word_type  mix;

   always_comb begin
      src = UPDATE_LEFT ? in_blk.right : in_blk.left;
      mix = ((src << 4) + key_a) ^ (src + ROUND_SUM) ^ ((src >> 5) + key_b);
      blk_in = in_blk;
      if (UPDATE_LEFT) begin
         blk_in.left = in_blk.left + mix;
      end else begin
         blk_in.right = in_blk.right + mix;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (stage_en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en) begin
         blk_ff <= blk_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_blk   = blk_ff;

endmodule

### rtl/core/tea_block_encrypt.sv
// ----------------------------------------------------------------------------
// TEA block encrypt
// Fully unrolled, pipelined TEA encryption of 64-bit blocks in ECB mode.
// ----------------------------------------------------------------------------
// The request stream carries one plaintext word per beat on req_tdata, and
// the response stream returns the matching ciphertext word on rsp_tdata in
// the same order. The 128-bit key is loaded as four 32-bit registers through
// the csr write channel, which is always ready; writes are expected only while
// the pipeline is empty, and writes to unknown indexes are dropped.
// Every TEA round is split into two register stages, one per half of the
// block, so the pipeline is 2*ROUND_COUNT stages deep, and a new word is
// accepted every cycle unless a response stall holds the pipeline. The depth
// of one stage is a single mix (shift-add, add, xor) plus the final add.
// The last stage is the output register. When the receiver stalls with a
// response pending, the whole pipeline holds in place and req_tready drops;
// nothing is lost or repeated. Reset clears all stage valid bits and the key
// registers to zero; the first word may be sent in the cycle after reset.
// ----------------------------------------------------------------------------
`include "tea_block_encrypt_defines.svh"

module tea_block_encrypt
   import tea_pkg::*;
#(
   parameter int ROUND_COUNT = DefRoundCount
) (
   input  logic                     clock,
   input  logic                     reset,
   // Request stream. req_tdata: plain_left [31:0], plain_right [63:32].
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [2*WordWidth-1:0]   req_tdata,
   // Response stream. rsp_tdata: cipher_left [31:0], cipher_right [63:32].
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [2*WordWidth-1:0]   rsp_tdata,
   // Key register write channel.
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [WordWidth-1:0]     csr_data
);

   localparam int NStage = 2 * ROUND_COUNT;

   word_type key0_ff, key1_ff, key2_ff, key3_ff;

   logic      stage_en;
   logic      stage_valid [NStage+1];
   block_type stage_blk   [NStage+1];

   // Key registers. The channel never back-pressures.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key0_ff <= '0;
         key1_ff <= '0;
         key2_ff <= '0;
         key3_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            KEY_WORD0_IDX: key0_ff <= csr_data;
            KEY_WORD1_IDX: key1_ff <= csr_data;
            KEY_WORD2_IDX: key2_ff <= csr_data;
            KEY_WORD3_IDX: key3_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // The pipeline moves as one whenever the output register is free or
   // its word is being taken this cycle.
   assign stage_en   = !rsp_tvalid || rsp_tready;
   assign req_tready = stage_en;

   assign stage_valid[0] = req_tvalid;
   assign stage_blk[0]   = block_type'(req_tdata);

   // Even stages update the left half with key words 0 and 1, odd stages
   // the right half with key words 2 and 3, both using the sum of their round.
   for (genvar s = 0; s < NStage; s++) begin : g_stage
      localparam bit UpdLeft = (s % 2) == 0;

      tea_half_round #(
         .UPDATE_LEFT (UpdLeft),
         .ROUND_SUM   (round_sum(s / 2))
      ) u_half (
         .clock     (clock),
         .reset     (reset),
         .stage_en  (stage_en),
         .in_valid  (stage_valid[s]),
         .in_blk    (stage_blk[s]),
         .key_a     (UpdLeft ? key0_ff : key2_ff),
         .key_b     (UpdLeft ? key1_ff : key3_ff),
         .out_valid (stage_valid[s+1]),
         .out_blk   (stage_blk[s+1])
      );
   end

   assign rsp_tvalid = stage_valid[NStage];
   assign rsp_tdata  = stage_blk[NStage];

   // A pending response that is not taken must freeze the request side.
   `TEA_ASSERT_IMP(a_stall_blocks_req, clock, reset, rsp_tvalid && !rsp_tready, !req_tready)
   // With no response pending, the block always takes a request.
   `TEA_ASSERT_IMP(a_idle_takes_req, clock, reset, !rsp_tvalid, req_tready)
   // An accepted request shows up as a valid first stage.
   `TEA_ASSERT_NEXT(a_req_enters, clock, reset, req_tvalid && req_tready, stage_valid[1])
   // Reset empties the pipeline.
   `TEA_ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset, !rsp_tvalid)

endmodule

### verif/tb_tea_block_encrypt.sv
// ----------------------------------------------------------------------------
// TEA block encrypt testbench
// Sends plaintext words through the encryption pipeline under several keys
// and checks every ciphertext word against a local model of the rounds or a table value.
// ----------------------------------------------------------------------------
// The bench starts with a short table of edge-case blocks, run under the
// reset key, an all-ones key and a mixed key, then sends random blocks in
// phases with a fresh key per phase. Both streams idle at random, one phase
// runs without any idling, and in another the receiver holds off long enough
// for the pipeline to fill and push back on the request side.
// ----------------------------------------------------------------------------
module tb_tea_block_encrypt;
   import tea_pkg::*;

   localparam int ROUNDS         = DefRoundCount;
   localparam int RESET_CYCLES   = 4;
   localparam int IDLE_PERCENT   = 31;
   localparam int DIRECTED_ROWS  = 8;
   localparam int DIRECTED_PASSES = 3;
   localparam int RANDOM_PHASES  = 5;
   localparam int PHASE_WORDS    = 90;
   localparam int HOLD_CYCLES    = 300;
   localparam int TAIL_CYCLES    = 2 * ROUNDS + 16;
   localparam int WATCHDOG_LIMIT = 2000;

   // Indexes that do not address a key register; writes there are dropped.
   localparam logic [CsrIndexWidth-1:0] FIRST_UNUSED_IDX = KEY_WORD3_IDX + 1'b1;
   localparam logic [CsrIndexWidth-1:0] LAST_UNUSED_IDX  = '1;

   // One row of the directed table. Block literals are written as the
   // right half followed by the left half, matching the packed layout.
   typedef struct {
      block_type plain;
      bit        typed;
      block_type cipher;
   } vector_row_type;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [2*WordWidth-1:0]   req_tdata;   // plain_left [31:0], plain_right [63:32]
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [2*WordWidth-1:0]   rsp_tdata;   // cipher_left [31:0], cipher_right [63:32]
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [WordWidth-1:0]     csr_data;

   // Local copy of the key registers, kept in step with every accepted write.
   word_type  key_shadow [4];
   // Ciphertext words still owed by the pipeline, oldest first.
   block_type cipher_queue [$];
   int        error_count;
   // Chance in percent that either stream side idles in a given cycle.
   int        idle_pct;
   // Set by the stimulus to ask the receiver for one long hold-off.
   bit        hold_off_req;

   // The all-zero block under the all-zero key gives the published TEA
   // test vector; every other row is checked against the local model.
   vector_row_type directed_rows [DIRECTED_ROWS] = '{
      '{64'h00000000_00000000, 1'b1, 64'h94baa940_41ea3a0a},
      '{64'hffffffff_ffffffff, 1'b0, 64'h0},
      '{64'haaaaaaaa_55555555, 1'b0, 64'h0},
      '{64'h55555555_aaaaaaaa, 1'b0, 64'h0},
      '{64'h00000000_ffffffff, 1'b0, 64'h0},
      '{64'hffffffff_00000000, 1'b0, 64'h0},
      '{64'h80000000_00000001, 1'b0, 64'h0},
      '{64'h00000001_80000000, 1'b0, 64'h0}
   };

   tea_block_encrypt #(
      .ROUND_COUNT (ROUNDS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // One half-update of a round: shift-add, add and xor of the other half.
   function automatic word_type tea_mix(word_type x, word_type sum,
                                        word_type ka, word_type kb);
      return ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
   endfunction

   // Full encryption of one block under the current key shadow.
   function automatic block_type tea_encipher(block_type plain);
      word_type  left;
      word_type  right;
      word_type  sum;
      block_type cipher;
      left  = plain.left;
      right = plain.right;
      sum   = '0;
      for (int n = 0; n < ROUNDS; n++) begin
         sum   = sum + TeaDelta;
         left  = left + tea_mix(right, sum, key_shadow[0], key_shadow[1]);
         right = right + tea_mix(left, sum, key_shadow[2], key_shadow[3]);
      end
      cipher.left  = left;
      cipher.right = right;
      return cipher;
   endfunction

   // Random word, biased toward zero, all ones and single set bits.
   function automatic word_type random_word();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         2: return word_type'(1) << $urandom_range(WordWidth - 1);
         default: return $urandom();
      endcase
   endfunction

   // Offers one plaintext word, idling first at random, and records the
   // ciphertext it must produce once the word has been accepted. A typed
   // expectation from the table takes the place of the model when given.
   task automatic send_block(input block_type plain, input bit typed,
                             input block_type typed_cipher);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= plain;
      do @(posedge clock); while (!req_tready);
      cipher_queue.push_back(typed ? typed_cipher : tea_encipher(plain));
   endtask

   // Stops offering and waits until every owed ciphertext word is back.
   // Every word yields a response, so an empty queue means an empty pipeline.
   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      while (cipher_queue.size() != 0)
         @(posedge clock);
   endtask

   // Writes one register; the caller lowers csr_valid after its last write.
   task automatic csr_write(input logic [CsrIndexWidth-1:0] index,
                            input word_type data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         KEY_WORD0_IDX: key_shadow[0] = data;
         KEY_WORD1_IDX: key_shadow[1] = data;
         KEY_WORD2_IDX: key_shadow[2] = data;
         KEY_WORD3_IDX: key_shadow[3] = data;
         default: ;
      endcase
   endtask

   // Writes all four key words; the caller lowers csr_valid afterwards.
   task automatic write_key(input word_type k0, input word_type k1,
                            input word_type k2, input word_type k3);
      csr_write(KEY_WORD0_IDX, k0);
      csr_write(KEY_WORD1_IDX, k1);
      csr_write(KEY_WORD2_IDX, k2);
      csr_write(KEY_WORD3_IDX, k3);
   endtask

   // Compares one accepted response word with the oldest expectation.
   task automatic check_cipher();
      block_type actual;
      block_type expected;
      actual = rsp_tdata;
      if (cipher_queue.size() == 0) begin
         $display("%0t: response word with nothing expected, got %h", $time, actual);
         error_count++;
      end else begin
         expected = cipher_queue.pop_front();
         if (actual.left !== expected.left) begin
            $display("%0t: cipher_left mismatch, expected %h, got %h",
                     $time, expected.left, actual.left);
            error_count++;
         end
         if (actual.right !== expected.right) begin
            $display("%0t: cipher_right mismatch, expected %h, got %h",
                     $time, expected.right, actual.right);
            error_count++;
         end
      end
   endtask

   // Receiver. Outputs are sampled right after the edge, so the values seen
   // are the ones that were stable while the edge happened. The long
   // hold-off is counted here, independent of what the sender is doing.
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      rsp_tready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready)
            check_cipher();
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (hold_off_req) begin
            hold_off_req = 1'b0;
            hold_left = HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= idle_pct);
         end
      end
   end

   // Watchdog: ends the run when no word moves on any channel for too long.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("simulation failed");
      $finish;
   end

   // Main stimulus.
   initial begin : stimulus
      clock        = 1'b0;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      csr_valid    = 1'b0;
      csr_index    = '0;
      csr_data     = '0;
      error_count  = 0;
      idle_pct     = IDLE_PERCENT;
      hold_off_req = 1'b0;
      for (int k = 0; k < 4; k++)
         key_shadow[k] = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed part. The first pass runs on the key left by reset, the
      // second on an all-ones key, and the third on a mixed key loaded
      // between writes to unused indexes, which must leave the key alone.
      for (int pass = 0; pass < DIRECTED_PASSES; pass++) begin
         if (pass == 1) begin
            write_key('1, '1, '1, '1);
            csr_valid <= 1'b0;
         end else if (pass == 2) begin
            csr_write(FIRST_UNUSED_IDX, 32'hdeadbeef);
            write_key(32'h01234567, 32'h89abcdef, 32'hfedcba98, 32'h76543210);
            csr_write(LAST_UNUSED_IDX, '1);
            csr_valid <= 1'b0;
         end
         for (int row = 0; row < DIRECTED_ROWS; row++)
            send_block(directed_rows[row].plain, (pass == 0) && directed_rows[row].typed,
                       directed_rows[row].cipher);
         drain_pipeline();
      end

      // Random part. Each phase loads a new key while the pipeline is empty.
      // Phase one runs with no idling at all, phase two asks the receiver
      // for its long hold-off, and phase three goes back to an all-zero key.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 3)
            write_key('0, '0, '0, '0);
         else
            write_key(random_word(), random_word(), random_word(), random_word());
         csr_write(CsrIndexWidth'($urandom_range(FIRST_UNUSED_IDX, LAST_UNUSED_IDX)),
                   random_word());
         csr_valid <= 1'b0;
         idle_pct = (phase == 1) ? 0 : IDLE_PERCENT;
         if (phase == 2)
            hold_off_req = 1'b1;
         for (int n = 0; n < PHASE_WORDS; n++)
            send_block({random_word(), random_word()}, 1'b0, '0);
         drain_pipeline();
      end

      // Let the pipeline run idle a while so a stray extra response shows up.
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
